### sv/hds_pkg.sv
// Package: constants, register addresses and helpers for the heat diffusion stencil block
package hds_pkg;
	localparam int MaxColsDef = 1024;
	localparam int MaxRowsDef = 1024;
	localparam logic [10:0] ColsReset = 11'd64;
	localparam logic [10:0] RowsReset = 11'd64;
	localparam logic [15:0] CoeffReset = 16'd16384;
	localparam logic [3:0] AddrCols = 4'h0;
	localparam logic [3:0] AddrRows = 4'h4;
	localparam logic [3:0] AddrCoeff = 4'h8;

	typedef struct packed {
		logic start;
		logic [63:0] sum;
		logic [21:0] count;
	} div_req_t;
endpackage

### sv/heat_diffusion_stencil_step.sv
// Top level: five-point heat stencil over two line memories with frame RMS change
// Results: up to 3 results per accepted word; output stalls delay them, and the input
// is held until the last result has left.
// Frame end: the last result waits for the 64-step divider and 32-step root.
// Reset: arst_n clears counters, sum, registers to reset values; line memories undefined.
module heat_diffusion_stencil_step #(
	parameter int MAX_COLS = hds_pkg::MaxColsDef,
	parameter int MAX_ROWS = hds_pkg::MaxRowsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] temperature_in,
	output logic out_valid,
	input  logic out_stall,
	output logic [9:0] out_row,
	output logic [9:0] out_col,
	output logic signed [31:0] temperature_out,
	output logic run_end,
	output logic frame_end,
	output logic [31:0] rms_change
);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [10:0] cols_reg_q, rows_reg_q;
	logic [15:0] coeff_q;
	logic [12:0] cols_c, rows_c;
	logic cfg_wr, geo_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign geo_wr = cfg_wr && (paddr == hds_pkg::AddrCols || paddr == hds_pkg::AddrRows);

	always_comb begin
		case (paddr)
			hds_pkg::AddrCols: prdata = {21'd0, cols_reg_q};
			hds_pkg::AddrRows: prdata = {21'd0, rows_reg_q};
			hds_pkg::AddrCoeff: prdata = {16'd0, coeff_q};
			default: prdata = '0;
		endcase
		if (cols_reg_q < 11'd3) cols_c = 13'd3;
		else if ({2'b0, cols_reg_q} > 13'(MAX_COLS)) cols_c = 13'(MAX_COLS);
		else cols_c = {2'b0, cols_reg_q};
		if (rows_reg_q < 11'd3) rows_c = 13'd3;
		else if ({2'b0, rows_reg_q} > 13'(MAX_ROWS)) rows_c = 13'(MAX_ROWS);
		else rows_c = {2'b0, rows_reg_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg_q <= hds_pkg::ColsReset;
			rows_reg_q <= hds_pkg::RowsReset;
			coeff_q <= hds_pkg::CoeffReset;
		end else if (cfg_wr) begin
			case (paddr)
				hds_pkg::AddrCols: cols_reg_q <= pwdata[10:0];
				hds_pkg::AddrRows: rows_reg_q <= pwdata[10:0];
				hds_pkg::AddrCoeff: coeff_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// stage 1: accept, memory read
	logic [31:0] upper_mem [MAX_COLS];
	logic [31:0] middle_mem [MAX_COLS];
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic accept;
	logic v_s1, lr_s1, lc_s1;
	logic [RW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic [31:0] x_s1, up_rd_s1, mid_rd_s1;
	logic last_row, last_col;
	logic hold;

	assign last_row = ({{(13-RW){1'b0}}, row_q} == rows_c - 13'd1);
	assign last_col = ({{(13-CW){1'b0}}, col_q} == cols_c - 13'd1);

	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1 <= upper_mem[col_q];
			mid_rd_s1 <= middle_mem[col_q];
			x_s1 <= temperature_in;
			r_s1 <= row_q;
			c_s1 <= col_q;
			lr_s1 <= last_row;
			lc_s1 <= last_col;
		end
	end

	// stage 2: result generation sequencer
	logic [31:0] mid_prev_q, mid_prev2_q, up_prev_q, prev_in_q;
	logic [63:0] sum_q;
	logic busy_s2;
	logic [1:0] idx_q;
	logic [2:0] rmask_s2;
	logic [RW-1:0] r_s2;
	logic [CW-1:0] c_s2;
	logic [31:0] x_s2, midc_s2, stv_s2;
	logic lr_s2, lc_s2;
	logic acc_s2;
	logic [32:0] mag_s2;
	logic rms_busy, rms_done;
	logic [31:0] rms_val;
	logic wait_rms_q;
	hds_pkg::div_req_t dreq;

	// stencil arithmetic on stage 1 values
	logic signed [35:0] lap;
	logic signed [53:0] prod;
	logic signed [37:0] delta;
	logic signed [38:0] nv;
	logic [31:0] nv_sat;
	logic signed [32:0] dif;
	logic [32:0] mag;
	logic [65:0] sq;
	logic [31:0] mid_c;

	assign mid_c = mid_rd_s1;
	always_comb begin
		lap = 36'(signed'(up_prev_q)) + 36'(signed'(prev_in_q)) + 36'(signed'(mid_prev2_q))
			+ 36'(signed'(mid_c)) - (36'(signed'(mid_prev_q)) <<< 2);
		prod = 54'(signed'({1'b0, coeff_q})) * 54'(lap);
		delta = 38'((prod + 54'sd32768) >>> 16);
		nv = 39'(signed'(mid_prev_q)) + 39'(delta);
		if (nv > 39'sd2147483647) nv_sat = 32'h7FFF_FFFF;
		else if (nv < -39'sd2147483648) nv_sat = 32'h8000_0000;
		else nv_sat = nv[31:0];
		dif = 33'(signed'(nv_sat)) - 33'(signed'(mid_prev_q));
		mag = dif[32] ? 33'(-dif) : 33'(dif);
	end

	// squared change of the cell registered in stage 2
	assign sq = (66'(mag_s2) * 66'(mag_s2)) >> 16;

	logic intr;
	logic [2:0] rmask;
	assign intr = (r_s1 >= RW'(2)) && (c_s1 >= CW'(2));
	assign rmask = {lr_s1, (r_s1 != '0) && lc_s1, (r_s1 != '0) && (c_s1 != '0)};

	// output register
	logic ov_q;
	logic out_free;
	assign out_free = !ov_q || !out_stall;
	assign hold = busy_s2 || wait_rms_q || rms_busy;
	assign in_stall = v_s1 || hold;
	assign accept = in_valid && !in_stall;

	logic [1:0] pick;
	logic [2:0] rem_mask;
	logic last_pick;
	always_comb begin
		rem_mask = rmask_s2;
		for (int k = 0; k < 3; k++) if (k < idx_q) rem_mask[k] = 1'b0;
		pick = rem_mask[0] ? 2'd0 : (rem_mask[1] ? 2'd1 : 2'd2);
		last_pick = (rem_mask & ~(3'b1 << pick)) == 3'd0;
	end

	logic [64:0] sum_add;
	logic [63:0] sum_sat;
	logic frame_s2, emit;
	assign sum_add = {1'b0, sum_q} + {1'b0, sq[63:0]} + {64'd0, |sq[65:64]};
	assign sum_sat = sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
	assign frame_s2 = lr_s2 && lc_s2;
	assign emit = busy_s2 && out_free && !(last_pick && frame_s2 && (wait_rms_q || acc_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1 <= 1'b0;
			busy_s2 <= 1'b0;
			acc_s2 <= 1'b0;
			ov_q <= 1'b0;
			wait_rms_q <= 1'b0;
			sum_q <= '0;
			mid_prev_q <= '0;
			mid_prev2_q <= '0;
			up_prev_q <= '0;
			prev_in_q <= '0;
			idx_q <= '0;
			dreq <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (out_free) ov_q <= 1'b0;
			if (geo_wr) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else col_q <= col_q + CW'(1);
			end
			if (accept) v_s1 <= 1'b1;
			else if (v_s1) v_s1 <= 1'b0;
			acc_s2 <= v_s1;
			if (v_s1) begin
				busy_s2 <= (rmask != 3'd0);
				idx_q <= '0;
				rmask_s2 <= rmask;
				r_s2 <= r_s1;
				c_s2 <= c_s1;
				x_s2 <= x_s1;
				midc_s2 <= mid_c;
				stv_s2 <= intr ? nv_sat : mid_prev_q;
				mag_s2 <= intr ? mag : 33'd0;
				lr_s2 <= lr_s1;
				lc_s2 <= lc_s1;
				mid_prev2_q <= mid_prev_q;
				mid_prev_q <= mid_c;
				up_prev_q <= up_rd_s1;
				prev_in_q <= x_s1;
			end else if (emit) begin
				idx_q <= pick + 2'd1;
				if (last_pick) busy_s2 <= 1'b0;
			end
			if (geo_wr) sum_q <= '0;
			else if (acc_s2) sum_q <= sum_sat;
			else if (emit && last_pick && frame_s2) sum_q <= '0;
			if (acc_s2 && frame_s2) begin
				dreq.start <= 1'b1;
				dreq.sum <= sum_sat;
				dreq.count <= 22'(cols_c * rows_c);
			end else begin
				dreq.start <= 1'b0;
			end
			if (rms_done) wait_rms_q <= 1'b0;
			else if (acc_s2 && frame_s2) wait_rms_q <= 1'b1;
			if (emit) begin
				out_row <= (pick == 2'd2) ? 10'(r_s2) : 10'(r_s2 - RW'(1));
				out_col <= (pick == 2'd0) ? 10'(c_s2 - CW'(1)) : 10'(c_s2);
				temperature_out <= (pick == 2'd0) ? stv_s2 : ((pick == 2'd1) ? midc_s2 : x_s2);
				run_end <= last_pick;
				frame_end <= last_pick && frame_s2;
				rms_change <= (last_pick && frame_s2) ? rms_val : 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			upper_mem[c_s1] <= mid_c;
			middle_mem[c_s1] <= x_s1;
		end
	end

	hds_rms u_rms (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.busy(rms_busy), .done(rms_done), .rms(rms_val)
	);

	assign out_valid = ov_q;

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s2 |-> in_stall) else $error("input taken while results pending");
	a_fe_runend: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> run_end) else $error("frame_end without run_end");
	a_rms_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_end) |-> (rms_change == 32'd0)) else $error("rms off frame end");
`endif
endmodule

### sv/hds_rms.sv
// Frame-end unit: mean by restoring division, then bitwise integer square root
module hds_rms (
	input  logic clk,
	input  logic arst_n,
	input  hds_pkg::div_req_t req,
	output logic busy,
	output logic done,
	output logic [31:0] rms
);
	typedef enum logic [1:0] {IDLE, DIV, SQRT} st_t;
	st_t st_q;
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic [21:0] den_q;
	logic [6:0] cnt_q;
	logic [63:0] x_q, res_q, bit_q;
	logic [64:0] rem_sh;
	logic [63:0] trial;

	assign busy = (st_q != IDLE);
	assign rem_sh = {rem_q[63:0], quo_q[63]};
	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
			rms <= '0;
		end else begin
			case (st_q)
				IDLE: begin
					done <= 1'b0;
					if (req.start) begin
						quo_q <= req.sum;
						rem_q <= '0;
						den_q <= req.count;
						cnt_q <= 7'd0;
						st_q <= DIV;
					end
				end
				DIV: begin
					done <= 1'b0;
					if (rem_sh >= {43'd0, den_q}) begin
						rem_q <= rem_sh - {43'd0, den_q};
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					if (cnt_q == 7'd63) begin
						st_q <= SQRT;
						cnt_q <= 7'd0;
						res_q <= '0;
						bit_q <= 64'd1 << 62;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				SQRT: begin
					if (cnt_q == 7'd0) begin
						if (quo_q[63:48] != 16'd0) begin
							rms <= 32'hFFFF_FFFF;
							done <= 1'b1;
							st_q <= IDLE;
						end else begin
							x_q <= {quo_q[47:0], 16'd0};
							cnt_q <= 7'd1;
							done <= 1'b0;
						end
					end else begin
						if (x_q >= trial) begin
							x_q <= x_q - trial;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
						cnt_q <= cnt_q + 7'd1;
						if (bit_q == 64'd1) begin
							rms <= 32'((x_q >= trial) ? ((res_q >> 1) + bit_q) : (res_q >> 1));
							done <= 1'b1;
							st_q <= IDLE;
						end else begin
							done <= 1'b0;
						end
					end
				end
				default: begin
					done <= 1'b0;
					st_q <= IDLE;
				end
			endcase
		end
	end
endmodule
